>>> sv/bba_pkg.sv
package bba_pkg;

	localparam int DEF_WORDS     = 16;
	localparam int DEF_WORD_BITS = 32;

	localparam int BLK_W  = 10;
	localparam int IDX_W  = 9;
	localparam int STAT_W = 2;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic             cmd;
		logic [BLK_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  granted_index;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic init_step;
		logic accept;
		logic scan;
		logic div;
		logic rd_quot;
		logic rel_wr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic hit;
		logic chk_last;
		logic out_range;
		logic out_free;
	} dp_stat_t;

endpackage

>>> sv/bba_datapath.sv
module bba_datapath #(
	parameter int WORDS     = bba_pkg::DEF_WORDS,
	parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::dp_cmd_t  cmd,
	output bba_pkg::dp_stat_t stat,
	input  bba_pkg::req_t     req,
	output bba_pkg::rsp_t     rsp,
	output logic              rsp_valid,
	input  logic              rsp_ready
);

	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int SH    = bba_pkg::BLK_W + $clog2(WORD_BITS);
	localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = bba_pkg::BLK_W + RW;
	localparam int TW    = $clog2(WORDS * WORD_BITS + 1);
	localparam int CW    = (TW > bba_pkg::BLK_W) ? TW : bba_pkg::BLK_W;
	localparam logic [CW-1:0] TOTAL = CW'(WORDS * WORD_BITS);
	localparam logic [AW-1:0] LAST  = AW'(WORDS - 1);

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] lowbit;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        chk_q;
	logic [AW-1:0]        quot_q;
	logic                 rd_en;
	logic                 wr_en;
	logic [BW-1:0]        bitpos;
	logic [BW-1:0]        rem_q;
	logic [bba_pkg::IDX_W-1:0] base_q;
	logic [PW-1:0]        prod;
	logic [CW-1:0]        qwb;
	bba_pkg::req_t        req_q;
	bba_pkg::rsp_t        res_q;
	bba_pkg::rsp_t        rsp_q;
	logic                 rsp_valid_q;

	// The lowest free entry of the word under test is isolated by a two's complement mask.
	always_comb begin
		lowbit = rdata_q & (~rdata_q + WORD_BITS'(1));
		bitpos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowbit[i]) begin
				bitpos = bitpos | BW'(i);
			end
		end
	end

	// Word number of a release index by multiplication with a reciprocal, exact for 10-bit indexes.
	assign prod = PW'(req_q.block_index) * PW'(RECIP);
	assign qwb  = CW'(quot_q) * CW'(WORD_BITS);

	assign stat.hit       = |rdata_q;
	assign stat.chk_last  = (chk_q == LAST);
	assign stat.init_last = (clr_q == LAST);
	assign stat.out_range = (CW'(req_q.block_index) >= TOTAL);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		if (cmd.accept) begin
			rd_en = 1'b1;
			raddr = '0;
		end else if (cmd.scan) begin
			rd_en = !stat.chk_last;
			raddr = chk_q + AW'(1);
		end else if (cmd.rd_quot) begin
			rd_en = 1'b1;
			raddr = quot_q;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		waddr = chk_q;
		wdata = rdata_q & ~lowbit;
		if (cmd.init_step) begin
			wr_en = 1'b1;
			waddr = clr_q;
			wdata = '1;
		end else if (cmd.scan) begin
			wr_en = stat.hit;
		end else if (cmd.rel_wr) begin
			wr_en = 1'b1;
			waddr = quot_q;
			wdata = rdata_q | (WORD_BITS'(1) << rem_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.init_step && !stat.init_last) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req;
			chk_q  <= '0;
			base_q <= '0;
		end
		if (cmd.scan) begin
			if (stat.hit) begin
				res_q.granted_index <= base_q + bba_pkg::IDX_W'(bitpos);
				res_q.status        <= bba_pkg::STATUS_OK;
			end else if (stat.chk_last) begin
				res_q.granted_index <= '0;
				res_q.status        <= bba_pkg::STATUS_FULL;
			end else begin
				chk_q  <= chk_q + AW'(1);
				base_q <= base_q + bba_pkg::IDX_W'(WORD_BITS);
			end
		end
		if (cmd.div) begin
			quot_q <= AW'(prod >> SH);
			if (stat.out_range) begin
				res_q.granted_index <= '0;
				res_q.status        <= bba_pkg::STATUS_RANGE;
			end
		end
		if (cmd.rd_quot) begin
			rem_q <= BW'(CW'(req_q.block_index) - qwb);
		end
		if (cmd.rel_wr) begin
			res_q.granted_index <= '0;
			res_q.status        <= bba_pkg::STATUS_OK;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> sv/bba_ctrl.sv
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_cmd,
	output logic              req_ready,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_RDQ,
		S_WRQ,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_cmd)
						bba_pkg::CMD_ALLOC:   state_d = S_SCAN;
						bba_pkg::CMD_RELEASE: state_d = S_DIV;
						default:              state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit || stat.chk_last) begin
					state_d = S_RESULT;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = stat.out_range ? S_RESULT : S_RDQ;
			end
			S_RDQ: begin
				cmd.rd_quot = 1'b1;
				state_d     = S_WRQ;
			end
			S_WRQ: begin
				cmd.rel_wr = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule

>>> sv/bitmap_block_allocator_core.sv
// Allocate: the request is accepted, the map words are scanned in order (up to WORDS), then the
// result is returned; the scan reads one word per cycle and stops at a word with a free entry.
// Release: accept, reciprocal divide, then a read-modify-write of one map word, then the response;
// an out-of-range release skips the map access and goes straight from the divide to the response.
// One request is in progress at a time; a finished response waits in an output register.
// After reset the free map is filled with ones word by word; no request is taken until it is full.
module bitmap_block_allocator_core #(
	parameter int WORDS     = bba_pkg::DEF_WORDS,
	parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bba_pkg::rsp_t rsp
);

	bba_pkg::dp_cmd_t  cmd;
	bba_pkg::dp_stat_t stat;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bba_datapath #(
		.WORDS     (WORDS),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule
